>>> hdl/pbl_pkg.sv
// ----------------------------------------------------------------------------
// pbl_pkg
// Shared types and constants for the premultiplied ARGB8888 pixel blender.
// ----------------------------------------------------------------------------
package pbl_pkg;

  localparam int unsigned PixW  = 32;
  localparam int unsigned ChanW = 8;
  localparam int unsigned NumCh = PixW / ChanW;
  localparam int unsigned ModeW = 2;

  localparam logic [ChanW-1:0] ChanMax = 8'hff;

  // Blend mode register codes; the unused code behaves as alpha clear.
  typedef enum logic [ModeW-1:0] {
    MODE_SRC_OVER    = 2'd0,
    MODE_ADD_SAT     = 2'd1,
    MODE_ALPHA_CLEAR = 2'd2
  } blend_mode_e;

  typedef struct packed {
    logic [PixW-1:0] src_pixel;
    logic [PixW-1:0] dst_pixel;
    logic            row_end;
  } pix_in_t;

  typedef struct packed {
    logic [PixW-1:0] out_pixel;
    logic            out_row_end;
  } pix_out_t;

endpackage

>>> hdl/pbl_scale.sv
// ----------------------------------------------------------------------------
// pbl_scale
// Scale all four channels of a pixel by k/255 with rounding.
// ----------------------------------------------------------------------------
module pbl_scale (
  input  logic [pbl_pkg::PixW-1:0]  pixel_i,
  input  logic [pbl_pkg::ChanW-1:0] k_i,
  output logic [pbl_pkg::PixW-1:0]  pixel_o
);

  localparam int unsigned ProdW = 2 * pbl_pkg::ChanW;

  for (genvar ch = 0; ch < pbl_pkg::NumCh; ch++) begin : g_chan
    logic [ProdW-1:0] prod;
    logic [ProdW:0]   t;
    logic [ProdW:0]   t2;

    // round(c * k / 255): add half, fold the high byte back in, take the high byte
    assign prod = ProdW'(pixel_i[ch*pbl_pkg::ChanW +: pbl_pkg::ChanW]) * ProdW'(k_i);
    assign t    = {1'b0, prod} + (ProdW+1)'(9'h080);
    assign t2   = t + {{pbl_pkg::ChanW{1'b0}}, t[ProdW:pbl_pkg::ChanW]};
    assign pixel_o[ch*pbl_pkg::ChanW +: pbl_pkg::ChanW] =
      t2[pbl_pkg::ChanW +: pbl_pkg::ChanW];
  end

endmodule

>>> hdl/pbl_blend_core.sv
// ----------------------------------------------------------------------------
// pbl_blend_core
// Combinational blend of one source and destination pixel pair.
// ----------------------------------------------------------------------------
module pbl_blend_core (
  input  pbl_pkg::blend_mode_e      mode_i,
  input  logic [pbl_pkg::PixW-1:0]  src_i,
  input  logic [pbl_pkg::PixW-1:0]  dst_i,
  output logic [pbl_pkg::PixW-1:0]  pixel_o
);

  logic [pbl_pkg::ChanW-1:0] sa;
  logic [pbl_pkg::ChanW-1:0] k;
  logic [pbl_pkg::PixW-1:0]  dst_scaled;
  logic [pbl_pkg::PixW-1:0]  over_sum;
  logic [pbl_pkg::PixW-1:0]  add_sum;
  logic                      sa_full;
  logic                      sa_zero;
  logic                      dst_zero;

  // Per-channel add clamped at 255, no carry between channels.
  function automatic logic [pbl_pkg::PixW-1:0] sat_add(
    input logic [pbl_pkg::PixW-1:0] a,
    input logic [pbl_pkg::PixW-1:0] b
  );
    logic [pbl_pkg::PixW-1:0] r;
    logic [pbl_pkg::ChanW:0]  s;
    r = '0;
    for (int ch = 0; ch < pbl_pkg::NumCh; ch++) begin
      s = {1'b0, a[ch*pbl_pkg::ChanW +: pbl_pkg::ChanW]}
        + {1'b0, b[ch*pbl_pkg::ChanW +: pbl_pkg::ChanW]};
      r[ch*pbl_pkg::ChanW +: pbl_pkg::ChanW] =
        s[pbl_pkg::ChanW] ? pbl_pkg::ChanMax : s[pbl_pkg::ChanW-1:0];
    end
    return r;
  endfunction

  assign sa       = src_i[pbl_pkg::PixW-1 -: pbl_pkg::ChanW];
  assign k        = pbl_pkg::ChanMax - sa;
  assign sa_full  = (sa == pbl_pkg::ChanMax);
  assign sa_zero  = (sa == '0);
  assign dst_zero = (dst_i == '0);

  pbl_scale u_scale (
    .pixel_i (dst_i),
    .k_i     (k),
    .pixel_o (dst_scaled)
  );

  assign over_sum = sat_add(dst_scaled, src_i);
  assign add_sum  = sat_add(src_i, dst_i);

  always_comb begin
    case (mode_i)
      pbl_pkg::MODE_SRC_OVER: begin
        // a clear source keeps the destination even when it is empty
        if (sa_full) begin
          pixel_o = src_i;
        end else if (sa_zero) begin
          pixel_o = dst_i;
        end else if (dst_zero) begin
          pixel_o = src_i;
        end else begin
          pixel_o = over_sum;
        end
      end
      pbl_pkg::MODE_ADD_SAT: begin
        pixel_o = add_sum;
      end
      default: begin
        // alpha clear, also taken by the unused code
        if (sa_full) begin
          pixel_o = '0;
        end else if (sa_zero || dst_zero) begin
          pixel_o = dst_i;
        end else begin
          pixel_o = dst_scaled;
        end
      end
    endcase
  end

endmodule

>>> hdl/premultiplied_pixel_blender.sv
// ----------------------------------------------------------------------------
// premultiplied_pixel_blender
// Streaming blender for premultiplied 0xaarrggbb pixels.
// ----------------------------------------------------------------------------
// One source/destination pixel pair enters per beat and one blended pixel
// leaves per beat. A beat is registered at the input, blended by a single
// pass of combinational logic (one 8x8 multiply per channel, rounding adds,
// a saturating add and the fast-path select), and registered again at the
// output, so an accepted beat passes through two register stages, and the
// sustained rate is one pixel per cycle while the output is not stalled.
// Both registers advance whenever the stage ahead is empty or moving, so an
// empty input register takes a new beat even while a finished result waits
// on a stalled output. The blend mode comes from
// the configuration channel, which is always ready; write it only while no
// pixel is in flight. Modes: source over, add with per-channel saturation,
// alpha clear (the unused code behaves as alpha clear). The row-end flag
// rides along unchanged.
// ----------------------------------------------------------------------------
module premultiplied_pixel_blender (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [pbl_pkg::ModeW-1:0]  cfg_data_i,
  // pixel input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  pbl_pkg::pix_in_t           in_data_i,
  // pixel output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output pbl_pkg::pix_out_t          out_data_o
);

  pbl_pkg::blend_mode_e      mode_q;
  logic                      in_valid_q;
  pbl_pkg::pix_in_t          in_data_q;
  logic                      out_valid_q;
  pbl_pkg::pix_out_t         out_data_q;
  logic                      out_adv;
  logic                      in_adv;
  logic [pbl_pkg::PixW-1:0]  blend_pixel;

  // The config channel never backpressures.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= pbl_pkg::MODE_SRC_OVER;
    end else if (cfg_valid_i) begin
      mode_q <= pbl_pkg::blend_mode_e'(cfg_data_i);
    end
  end

  // Output register loads when empty or when its beat is being taken.
  assign out_adv = !out_valid_q || !out_stall_i;
  // Input register loads when empty or when it moves into the output register.
  assign in_adv  = !in_valid_q || out_adv;

  assign in_stall_o = !in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_adv) begin
        in_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers: hold while stalled, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_i) begin
      in_data_q <= in_data_i;
    end
    if (out_adv && in_valid_q) begin
      out_data_q.out_pixel   <= blend_pixel;
      out_data_q.out_row_end <= in_data_q.row_end;
    end
  end

  pbl_blend_core u_core (
    .mode_i  (mode_q),
    .src_i   (in_data_q.src_pixel),
    .dst_i   (in_data_q.dst_pixel),
    .pixel_o (blend_pixel)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
